// ===== design/htd_pkg.sv =====
// Shared types, widths and codes for the Huffman tree walk decoder.
// No dependencies; imported by every module of the block but htd_ram.
package htd_pkg;

    // Fixed field widths
    localparam int SYM_W  = 8;   // symbol field on the ports
    localparam int IDX_W  = 9;   // node index
    localparam int CNT_W  = 10;  // node count, holds MAX_NODES itself
    localparam int LVL_W  = 9;   // open slot count, holds STACK_DEPTH itself
    localparam int KIND_W = 2;
    localparam int ERR_W  = 2;

    // Stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Parameter defaults
    localparam int DEF_MAX_NODES   = 511;
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_SYMBOL_BITS = 8;

    // Item action selector
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NODES_FULL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_STACK_FULL = 2'd2;
    localparam logic [ERR_W-1:0] ERR_NOT_READY  = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [SYM_W-1:0] sym_t;

    // One result item
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        sym_t              sym;
        logic [ERR_W-1:0]  err;
    } res_t;

    // Node table write requests from the builder
    typedef struct packed {
        logic info_we;      // write leaf flag and symbol of node_idx
        logic child_we;     // write a child pointer of parent_idx
        logic child_right;  // 1: right pointer, 0: left pointer
        idx_t node_idx;
        idx_t parent_idx;
        logic leaf;
        sym_t sym;
    } node_wr_t;

    // Tree status and the root node kept in flops
    typedef struct packed {
        logic ready;
        logic leaf;
        sym_t sym;
        idx_t left;
        idx_t right;
    } root_t;

    // Item in flight between input and result register
    typedef struct packed {
        logic is_dec;
        logic ready;
        logic root_leaf;
        sym_t root_sym;
        res_t load_res;
    } s1_t;

endpackage

// ===== design/huffman_tree_decoder.sv =====
// An accepted input item passes the middle stage register, then the result register.
// One item per cycle unless stalled; a decode item costs one node table read (one tree level).
// A result held by m_axis_tready low keeps the middle stage full, which then stalls the input.
// Loads update the builder at accept; decodes resolve in the middle stage from the read data.
// Reset (rst_n, async, active low) clears counters, tree status, walk position and valids.
// Node table and slot stack contents are undefined after reset; no clearing pass is run.
module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // is_root, is_leaf, symbol_in[7:0], code_bit
    input  logic [0:0]            s_axis_tuser,  // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // symbol_out[7:0], error_code[1:0]
    output logic [KIND_W-1:0]     m_axis_tuser   // kind
);

    localparam int NAW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int OUT_PAD = OUT_DATA_W - SYM_W - ERR_W;

    logic       action;
    logic       is_root;
    logic       is_leaf;
    sym_t       symbol_in;
    logic       code_bit;
    sym_t       sym_masked;

    logic       accept;
    logic       out_free;
    logic       s1_done;
    logic       s1_fire;
    logic       s1_valid_reg;
    s1_t        s1_reg;
    s1_t        s1_next;
    res_t       s1_out;
    logic       out_valid_reg;
    res_t       out_res_reg;

    res_t       load_res;
    logic       walk_reset;
    node_wr_t   node_wr;
    root_t      root;
    idx_t       rd_addr;
    res_t       dec_res;

    logic [SYMBOL_BITS:0]   info_wdata;
    logic [SYMBOL_BITS:0]   info_rdata;
    logic                   info_leaf;
    sym_t                   info_sym;
    idx_t                   rd_left;
    idx_t                   rd_right;
    logic                   node_re;

    // Input field unpacking
    assign action     = s_axis_tuser[0];
    assign is_root    = s_axis_tdata[0];
    assign is_leaf    = s_axis_tdata[1];
    assign symbol_in  = s_axis_tdata[9:2];
    assign code_bit   = s_axis_tdata[10];
    assign sym_masked = SYM_W'(symbol_in[SYMBOL_BITS-1:0]);

    // Pipeline handshake: middle stage moves on unless its result is blocked
    assign s1_out        = s1_reg.is_dec ? dec_res : s1_reg.load_res;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_done       = !s1_out.valid || out_free;
    assign s1_fire       = s1_valid_reg && s1_done;
    assign s_axis_tready = !s1_valid_reg || s1_done;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign node_re       = accept && (action == ACT_DECODE);

    htd_builder
    #(
        .MAX_NODES   (MAX_NODES),
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_builder
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_fire  (accept && (action == ACT_LOAD)),
        .is_root    (is_root),
        .is_leaf    (is_leaf),
        .sym        (sym_masked),
        .load_res   (load_res),
        .walk_reset (walk_reset),
        .node_wr    (node_wr),
        .root       (root)
    );

    htd_walker u_walker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_fire    (s1_fire),
        .s1         (s1_reg),
        .walk_reset (walk_reset),
        .code_bit   (code_bit),
        .root       (root),
        .info_leaf  (info_leaf),
        .info_sym   (info_sym),
        .rd_left    (rd_left),
        .rd_right   (rd_right),
        .rd_addr    (rd_addr),
        .dec_res    (dec_res)
    );

    // Node table, split into leaf/symbol, left pointer and right pointer
    assign info_wdata = {node_wr.leaf, node_wr.sym[SYMBOL_BITS-1:0]};
    assign info_leaf  = info_rdata[SYMBOL_BITS];
    assign info_sym   = SYM_W'(info_rdata[SYMBOL_BITS-1:0]);

    htd_ram
    #(
        .WIDTH (SYMBOL_BITS + 1),
        .DEPTH (MAX_NODES)
    )
    u_info_ram
    (
        .clk   (clk),
        .we    (node_wr.info_we),
        .waddr (node_wr.node_idx[NAW-1:0]),
        .wdata (info_wdata),
        .re    (node_re),
        .raddr (rd_addr[NAW-1:0]),
        .rdata (info_rdata)
    );

    htd_ram
    #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_NODES)
    )
    u_left_ram
    (
        .clk   (clk),
        .we    (node_wr.child_we && !node_wr.child_right),
        .waddr (node_wr.parent_idx[NAW-1:0]),
        .wdata (node_wr.node_idx),
        .re    (node_re),
        .raddr (rd_addr[NAW-1:0]),
        .rdata (rd_left)
    );

    htd_ram
    #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_NODES)
    )
    u_right_ram
    (
        .clk   (clk),
        .we    (node_wr.child_we && node_wr.child_right),
        .waddr (node_wr.parent_idx[NAW-1:0]),
        .wdata (node_wr.node_idx),
        .re    (node_re),
        .raddr (rd_addr[NAW-1:0]),
        .rdata (rd_right)
    );

    // Middle stage capture
    always_comb
    begin
        s1_next           = '0;
        s1_next.is_dec    = (action == ACT_DECODE);
        s1_next.ready     = root.ready;
        s1_next.root_leaf = root.leaf;
        s1_next.root_sym  = root.sym;
        s1_next.load_res  = load_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !s1_done);
            out_valid_reg <= (s1_fire && s1_out.valid) || (out_valid_reg && !m_axis_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_fire && s1_out.valid)
        begin
            out_res_reg <= s1_out;
        end
    end

    // Result output
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_res_reg.err, out_res_reg.sym};

`ifndef SYNTHESIS
    a_blocked_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_out.valid && !out_free |=> s1_valid_reg)
        else $error("blocked result dropped from middle stage");

    a_stall_only_on_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    a_err_only_with_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.kind != KIND_ERROR) |-> out_res_reg.err == ERR_NONE)
        else $error("error code set on a non-error result");
`endif

endmodule

// ===== design/htd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-cycle write. Uses no package.
module htd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/htd_builder.sv =====
// Tree builder: open-slot stack, node count, tree status and root node.
// Depends on htd_pkg and htd_ram (right-slot stack below the top entry).
module htd_builder
    import htd_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load_fire,
    input  logic     is_root,
    input  logic     is_leaf,
    input  sym_t     sym,
    output res_t     load_res,
    output logic     walk_reset,
    output node_wr_t node_wr,
    output root_t    root
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LW1 = LVL_W + 1;

    // Open slots = pending left slot of the last internal node plus the
    // right slots; the top right slot lives in top_reg, the rest in RAM.
    logic [CNT_W-1:0] node_count_reg, node_count_next;
    logic [LVL_W-1:0] rcount_reg, rcount_next;
    logic             left_pend_reg, left_pend_next;
    idx_t             top_reg, top_next;
    logic             ready_reg, ready_next;
    logic             root_leaf_reg, root_leaf_next;
    sym_t             root_sym_reg, root_sym_next;
    idx_t             root_left_reg, root_left_next;
    idx_t             root_right_reg, root_right_next;
    logic             byp_valid_reg, byp_valid_next;
    idx_t             byp_data_reg;

    logic [LW1-1:0]   level;
    logic             level_empty;
    logic             cnt_full;
    logic             stk_full;
    idx_t             below;
    idx_t             node_idx;
    idx_t             parent;
    logic [LVL_W-1:0] base_r;
    logic [LVL_W-1:0] base_m1;
    logic [LVL_W-1:0] rdiff;
    idx_t             top_base;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr;
    idx_t             stk_wdata;
    logic [SAW-1:0]   stk_raddr;
    idx_t             stk_rdata;

    assign level       = LW1'(rcount_reg) + LW1'(left_pend_reg);
    assign level_empty = (level == '0);
    assign cnt_full    = (node_count_reg >= CNT_W'(MAX_NODES));
    assign stk_full    = ((level + LW1'(1)) > LW1'(STACK_DEPTH));
    assign below       = byp_valid_reg ? byp_data_reg : stk_rdata;
    assign node_idx    = is_root ? '0 : node_count_reg[IDX_W-1:0];

    // Load decision and next state
    always_comb
    begin
        node_count_next = node_count_reg;
        rcount_next     = rcount_reg;
        left_pend_next  = left_pend_reg;
        top_next        = top_reg;
        ready_next      = ready_reg;
        root_leaf_next  = root_leaf_reg;
        root_sym_next   = root_sym_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        load_res        = '0;
        walk_reset      = 1'b0;
        node_wr         = '0;
        node_wr.node_idx = node_idx;
        node_wr.leaf     = is_leaf;
        node_wr.sym      = sym;
        parent          = '0;
        base_r          = '0;
        base_m1         = '0;
        top_base        = top_reg;
        stk_we          = 1'b0;

        if (load_fire)
        begin
            priority if (!is_root && level_empty)
            begin
                load_res.valid = 1'b1;
                load_res.kind  = KIND_ERROR;
                load_res.err   = ERR_NOT_READY;
            end
            else if (!is_root && cnt_full)
            begin
                load_res.valid = 1'b1;
                load_res.kind  = KIND_ERROR;
                load_res.err   = ERR_NODES_FULL;
                rcount_next    = '0;
                left_pend_next = 1'b0;
                ready_next     = 1'b0;
                walk_reset     = 1'b1;
            end
            else if (!is_root && !is_leaf && stk_full)
            begin
                load_res.valid = 1'b1;
                load_res.kind  = KIND_ERROR;
                load_res.err   = ERR_STACK_FULL;
                rcount_next    = '0;
                left_pend_next = 1'b0;
                ready_next     = 1'b0;
                walk_reset     = 1'b1;
            end
            else
            begin
                walk_reset      = 1'b1;
                node_wr.info_we = 1'b1;
                node_count_next = CNT_W'(node_idx) + CNT_W'(1);
                if (is_root)
                begin
                    ready_next     = 1'b0;
                    root_leaf_next = is_leaf;
                    root_sym_next  = sym;
                end
                else
                begin
                    // Take the next open slot, left before right
                    node_wr.child_we = 1'b1;
                    if (left_pend_reg)
                    begin
                        parent   = node_count_reg[IDX_W-1:0] - IDX_W'(1);
                        base_r   = rcount_reg;
                        top_base = top_reg;
                    end
                    else
                    begin
                        parent              = top_reg;
                        node_wr.child_right = 1'b1;
                        base_r              = rcount_reg - LVL_W'(1);
                        top_base            = below;
                    end
                    if (parent == '0)
                    begin
                        if (left_pend_reg)
                        begin
                            root_left_next = node_idx;
                        end
                        else
                        begin
                            root_right_next = node_idx;
                        end
                    end
                end
                node_wr.parent_idx = parent;

                if (!is_leaf)
                begin
                    // Open both child slots: right one pushed, left one pending
                    left_pend_next = 1'b1;
                    rcount_next    = base_r + LVL_W'(1);
                    top_next       = node_idx;
                    base_m1        = base_r - LVL_W'(1);
                    stk_we         = (base_r != '0);
                end
                else
                begin
                    left_pend_next = 1'b0;
                    rcount_next    = base_r;
                    top_next       = top_base;
                    if (base_r == '0)
                    begin
                        ready_next     = 1'b1;
                        load_res.valid = 1'b1;
                        load_res.kind  = KIND_DONE;
                        load_res.err   = ERR_NONE;
                    end
                end
            end
        end
    end

    // Stack RAM ports; read is prefetched for the entry below the new top
    assign stk_waddr      = base_m1[SAW-1:0];
    assign stk_wdata      = top_base;
    assign rdiff          = rcount_next - LVL_W'(2);
    assign stk_raddr      = (rcount_next >= LVL_W'(2)) ? rdiff[SAW-1:0] : '0;
    assign byp_valid_next = stk_we && (stk_waddr == stk_raddr);

    htd_ram
    #(
        .WIDTH (IDX_W),
        .DEPTH (STACK_DEPTH)
    )
    u_slot_ram
    (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (1'b1),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            rcount_reg     <= '0;
            left_pend_reg  <= 1'b0;
            ready_reg      <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            rcount_reg     <= rcount_next;
            left_pend_reg  <= left_pend_next;
            ready_reg      <= ready_next;
            byp_valid_reg  <= byp_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        root_leaf_reg  <= root_leaf_next;
        root_sym_reg   <= root_sym_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        byp_data_reg   <= stk_wdata;
    end

    assign root.ready = ready_reg;
    assign root.leaf  = root_leaf_reg;
    assign root.sym   = root_sym_reg;
    assign root.left  = root_left_reg;
    assign root.right = root_right_reg;

`ifndef SYNTHESIS
    a_ready_no_open_slots: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (rcount_reg == '0) && !left_pend_reg)
        else $error("tree ready with open slots");

    a_left_has_right: assert property (@(posedge clk) disable iff (!rst_n)
        left_pend_reg |-> (rcount_reg != '0))
        else $error("pending left slot without its right slot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= CNT_W'(MAX_NODES))
        else $error("node count beyond table size");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LW1'(STACK_DEPTH))
        else $error("open slots beyond stack depth");
`endif

endmodule

// ===== design/htd_walker.sv =====
// Tree walker: current walk position, next node read address and the
// decode result of the item in the middle stage. Depends on htd_pkg.
module htd_walker
    import htd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s1_fire,
    input  s1_t   s1,
    input  logic  walk_reset,
    input  logic  code_bit,
    input  root_t root,
    input  logic  info_leaf,
    input  sym_t  info_sym,
    input  idx_t  rd_left,
    input  idx_t  rd_right,
    output idx_t  rd_addr,
    output res_t  dec_res
);

    // Walk position: at the root, or at an internal node whose children
    // are held in cur_left/cur_right
    logic at_root_reg, at_root_eff;
    idx_t cur_left_reg, cur_left_eff;
    idx_t cur_right_reg, cur_right_eff;
    logic active;

    assign active = s1.is_dec && s1.ready && !s1.root_leaf;

    // Decode result for the item in the middle stage
    always_comb
    begin
        dec_res = '0;
        if (!s1.ready)
        begin
            dec_res.valid = 1'b1;
            dec_res.kind  = KIND_ERROR;
            dec_res.err   = ERR_NOT_READY;
        end
        else if (s1.root_leaf)
        begin
            dec_res.valid = 1'b1;
            dec_res.kind  = KIND_SYMBOL;
            dec_res.sym   = s1.root_sym;
        end
        else if (info_leaf)
        begin
            dec_res.valid = 1'b1;
            dec_res.kind  = KIND_SYMBOL;
            dec_res.sym   = info_sym;
        end
    end

    // Position after the middle-stage item, forwarded to the next read
    always_comb
    begin
        at_root_eff   = at_root_reg;
        cur_left_eff  = cur_left_reg;
        cur_right_eff = cur_right_reg;
        if (s1_fire && active)
        begin
            if (info_leaf)
            begin
                at_root_eff = 1'b1;
            end
            else
            begin
                at_root_eff   = 1'b0;
                cur_left_eff  = rd_left;
                cur_right_eff = rd_right;
            end
        end
    end

    // Child chosen by the incoming code bit
    always_comb
    begin
        if (at_root_eff)
        begin
            rd_addr = code_bit ? root.right : root.left;
        end
        else
        begin
            rd_addr = code_bit ? cur_right_eff : cur_left_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_root_reg <= 1'b1;
        end
        else
        begin
            at_root_reg <= walk_reset || at_root_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_left_reg  <= cur_left_eff;
        cur_right_reg <= cur_right_eff;
    end

endmodule

// ===== tb/huffman_tree_decoder_check.sv =====
`timescale 1ns / 1ps
// Checker for huffman_tree_decoder: watches both stream channels and rebuilds and
// walks its own copy of the code tree for every accepted input item.
// Depends on htd_pkg for widths, action selectors, result kinds and error codes.
module huffman_tree_decoder_check
    import htd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // is_root, is_leaf, symbol_in[7:0], code_bit
    input  logic [0:0]            s_axis_tuser,   // action
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // symbol_out[7:0], error_code[1:0]
    input  logic [KIND_W-1:0]     m_axis_tuser,   // kind
    output int                    fail_count,
    output int                    due_count
);

    localparam int NODE_N = DEF_MAX_NODES;
    localparam int SLOT_N = DEF_STACK_DEPTH;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        sym_t              sym;
        logic [ERR_W-1:0]  err;
    } walk_res_t;

    // Tree copy: node = {leaf, symbol, left, right}, slot = {right side, parent}
    logic [26:0]  node_mem [0:NODE_N-1];
    logic [9:0]   slot_mem [0:SLOT_N-1];
    int unsigned  open_slots;
    int unsigned  nodes_loaded;
    bit           tree_ok;
    idx_t         walk_pos;
    walk_res_t    results_due[$];

    function automatic void abandon_build();
        open_slots = 0;
        tree_ok    = 1'b0;
        walk_pos   = '0;
    endfunction

    // Applies one item to the tree copy; returns 1 when it yields a result item
    function automatic bit tree_step(input logic act, input logic root, input logic leaf,
                                     input sym_t s, input logic b, output walk_res_t r);
        logic [26:0] entry;
        logic [26:0] pv;
        logic [26:0] cur;
        logic [26:0] cv;
        logic [9:0]  slot;
        idx_t        parent;
        idx_t        child;
        idx_t        here;
        r = '0;
        // Decode: one tree level per bit
        if (act == ACT_DECODE) begin
            if (!tree_ok) begin
                r.kind = KIND_ERROR;
                r.err  = ERR_NOT_READY;
                return 1'b1;
            end
            cur = node_mem[walk_pos];
            // single-leaf tree: every bit gives the root symbol
            if (cur[26]) begin
                walk_pos = '0;
                r.kind   = KIND_SYMBOL;
                r.sym    = cur[25:18];
                return 1'b1;
            end
            child = b ? cur[8:0] : cur[17:9];
            cv    = node_mem[child];
            if (cv[26]) begin
                walk_pos = '0;
                r.kind   = KIND_SYMBOL;
                r.sym    = cv[25:18];
                return 1'b1;
            end
            walk_pos = child;
            return 1'b0;
        end
        // Load: attach the node to the next open slot
        entry = leaf ? {1'b1, s, 18'd0} : 27'd0;
        if (root) begin
            nodes_loaded = 0;
            open_slots   = 0;
            tree_ok      = 1'b0;
            walk_pos     = '0;
        end
        else begin
            if (open_slots == 0) begin
                r.kind = KIND_ERROR;
                r.err  = ERR_NOT_READY;
                return 1'b1;
            end
            if (nodes_loaded >= NODE_N) begin
                abandon_build();
                r.kind = KIND_ERROR;
                r.err  = ERR_NODES_FULL;
                return 1'b1;
            end
            if (!leaf && open_slots + 1 > SLOT_N) begin
                abandon_build();
                r.kind = KIND_ERROR;
                r.err  = ERR_STACK_FULL;
                return 1'b1;
            end
            open_slots--;
            slot   = slot_mem[open_slots];
            parent = slot[8:0];
            pv     = node_mem[parent];
            if (slot[9])
                pv[8:0] = idx_t'(nodes_loaded);
            else
                pv[17:9] = idx_t'(nodes_loaded);
            node_mem[parent] = pv;
        end
        here = idx_t'(nodes_loaded);
        node_mem[here] = entry;
        nodes_loaded++;
        // internal node: right slot below left, so left is filled first
        if (!leaf) begin
            slot_mem[open_slots]     = {1'b1, here};
            slot_mem[open_slots + 1] = {1'b0, here};
            open_slots += 2;
            return 1'b0;
        end
        if (open_slots == 0) begin
            tree_ok  = 1'b1;
            walk_pos = '0;
            r.kind   = KIND_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare outgoing items first, then account for the incoming item
    always @(posedge clk or negedge rst_n)
    begin
        walk_res_t want;
        walk_res_t got;
        bit        made;
        if (!rst_n) begin
            open_slots   = 0;
            nodes_loaded = 0;
            tree_ok      = 1'b0;
            walk_pos     = '0;
            results_due.delete();
            due_count    = 0;
            fail_count   = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.sym  = m_axis_tdata[7:0];
                got.err  = m_axis_tdata[9:8];
                if (results_due.size() == 0) begin
                    $display("%0t: result item with none due: kind %0d symbol %h error %0d",
                             $time, got.kind, got.sym, got.err);
                    fail_count++;
                end
                else begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind) begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.sym !== want.sym) begin
                        $display("%0t: symbol_out expected %h actual %h",
                                 $time, want.sym, got.sym);
                        fail_count++;
                    end
                    if (got.err !== want.err) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.err, got.err);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                made = tree_step(s_axis_tuser[0], s_axis_tdata[0], s_axis_tdata[1],
                                 s_axis_tdata[9:2], s_axis_tdata[10], want);
                if (made)
                    results_due.insert(results_due.size(), want);
            end
            due_count = results_due.size();
        end
    end

endmodule

// ===== tb/huffman_tree_decoder_test.sv =====
`timescale 1ns / 1ps
// Testbench top for huffman_tree_decoder: drives tree loads and code bits with random
// pauses on both stream sides and gives the verdict.
// Needs htd_pkg, the block and huffman_tree_decoder_check.
module huffman_tree_decoder_test;
    import htd_pkg::*;

    localparam int N_ITEMS       = 1150;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 10;
    localparam int NODE_N        = DEF_MAX_NODES;
    localparam int SLOT_N        = DEF_STACK_DEPTH;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // is_root, is_leaf, symbol_in[7:0], code_bit
    logic [0:0]            s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // symbol_out[7:0], error_code[1:0]
    logic [KIND_W-1:0]     m_axis_tuser;   // kind

    int fail_count;
    int due_count;
    int items_sent;
    int idle_cycles;
    int take_hold;
    bit send_calm;
    bit take_calm;
    bit draining;
    bit swept_stack;
    bit swept_nodes;

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    huffman_tree_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    huffman_tree_decoder_check chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .due_count     (due_count)
    );

    // Pause length: mostly none, some short, a few long
    function automatic int draw_pause(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Receiver side stalls
    always @(negedge clk)
    begin
        if (draining) begin
            m_axis_tready <= 1'b1;
        end
        else if (take_hold > 0) begin
            m_axis_tready <= 1'b0;
            take_hold--;
        end
        else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 299) == 0)
                take_calm = !take_calm;
            take_hold = draw_pause(take_calm);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[huffman_tree_decoder] ERROR");
                $finish;
            end
        end
    end

    // Present one item at a falling edge and hold it until accepted
    task automatic send_raw(input logic act, input logic [IN_DATA_W-1:0] data);
        int gap;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
        if ($urandom_range(0, 149) == 0)
            send_calm = !send_calm;
        gap = draw_pause(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_item(input logic act, input logic root, input logic leaf,
                             input sym_t s, input logic b);
        send_raw(act, {{(IN_DATA_W-11){1'b0}}, b, s, leaf, root});
    endtask

    // Random full binary tree in preorder; stops early after stop_at nodes
    task automatic send_tree(input int internals, input int bias, input int stop_at);
        int open_slots;
        int n;
        int left;
        bit inner;
        open_slots = 1;
        n = 0;
        left = internals;
        while (open_slots > 0 && n != stop_at) begin
            inner = (left > 0) && ($urandom_range(0, 99) < bias);
            send_item(ACT_LOAD, n == 0, !inner, 8'($urandom), 1'($urandom));
            if (inner) begin
                open_slots++;
                left--;
            end
            else begin
                open_slots--;
            end
            n++;
        end
    endtask

    // Code bits with random filler in the load fields
    task automatic send_bits(input int count, input int one_pct);
        repeat (count)
            send_item(ACT_DECODE, 1'($urandom), 1'($urandom), 8'($urandom),
                      $urandom_range(0, 99) < one_pct);
    endtask

    initial
    begin
        int pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        items_sent    = 0;
        idle_cycles   = 0;
        take_hold     = 0;
        send_calm     = 1'b0;
        take_calm     = 1'b0;
        draining      = 1'b0;
        swept_stack   = 1'b0;
        swept_nodes   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // decode and non-root load with no tree held
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b0);
        send_item(ACT_DECODE, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_item(ACT_LOAD, 1'b0, 1'b1, 8'h3C, 1'b0);
        // single-leaf trees
        send_item(ACT_LOAD, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b0);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b1);
        send_item(ACT_LOAD, 1'b0, 1'b0, 8'h11, 1'b0);
        send_item(ACT_LOAD, 1'b1, 1'b1, 8'h00, 1'b0);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b1);
        // three-leaf tree and every path through it
        send_item(ACT_LOAD, 1'b1, 1'b0, 8'h00, 1'b0);
        send_item(ACT_LOAD, 1'b0, 1'b1, 8'h01, 1'b1);
        send_item(ACT_LOAD, 1'b0, 1'b0, 8'h00, 1'b0);
        send_item(ACT_LOAD, 1'b0, 1'b1, 8'h80, 1'b0);
        send_item(ACT_LOAD, 1'b0, 1'b1, 8'h7F, 1'b1);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b0);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b1);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b0);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b1);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b1);
        // new root in the middle of a build
        send_item(ACT_LOAD, 1'b1, 1'b0, 8'h00, 1'b0);
        send_item(ACT_LOAD, 1'b0, 1'b1, 8'hA5, 1'b0);
        send_item(ACT_LOAD, 1'b1, 1'b1, 8'h5A, 1'b0);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b0);
        // decode while a build is open
        send_item(ACT_LOAD, 1'b1, 1'b0, 8'h00, 1'b0);
        send_item(ACT_DECODE, 1'b0, 1'b0, 8'h00, 1'b1);

        // Random part, with two long sweeps for the overflow cases
        while (items_sent < N_ITEMS) begin
            if (!swept_stack && items_sent >= 200) begin
                // left-leaning chain of internal nodes until the slot stack overflows
                send_item(ACT_LOAD, 1'b1, 1'b0, 8'($urandom), 1'($urandom));
                repeat (SLOT_N - 1)
                    send_item(ACT_LOAD, 1'b0, 1'b0, 8'($urandom), 1'($urandom));
                send_bits(1, 50);
                send_item(ACT_LOAD, 1'b0, 1'($urandom), 8'($urandom), 1'($urandom));
                swept_stack = 1'b1;
            end
            else if (!swept_nodes && items_sent >= 550) begin
                // internal/leaf pairs keep two slots open until the table is full
                send_item(ACT_LOAD, 1'b1, 1'b0, 8'($urandom), 1'($urandom));
                repeat ((NODE_N - 1) / 2) begin
                    send_item(ACT_LOAD, 1'b0, 1'b0, 8'($urandom), 1'($urandom));
                    send_item(ACT_LOAD, 1'b0, 1'b1, 8'($urandom), 1'($urandom));
                end
                send_item(ACT_LOAD, 1'b0, 1'($urandom), 8'($urandom), 1'($urandom));
                send_bits(1, 50);
                swept_nodes = 1'b1;
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // complete tree, then a run of code bits
                    if ($urandom_range(0, 9) == 0)
                        send_tree($urandom_range(20, 60), $urandom_range(40, 80), -1);
                    else
                        send_tree($urandom_range(0, 10), $urandom_range(30, 80), -1);
                    send_bits($urandom_range(4, 40), $urandom_range(10, 90));
                end
                else if (pick < 72) begin
                    // build cut short, then bits
                    send_tree($urandom_range(2, 12), 70, $urandom_range(1, 6));
                    send_bits($urandom_range(1, 3), 50);
                end
                else if (pick < 80) begin
                    repeat ($urandom_range(1, 3))
                        send_item(ACT_LOAD, 1'b0, 1'($urandom), 8'($urandom), 1'($urandom));
                end
                else if (pick < 92) begin
                    repeat ($urandom_range(1, 6))
                        send_raw(1'($urandom), IN_DATA_W'($urandom_range(0, 2047)));
                end
                else begin
                    send_bits($urandom_range(1, 10), 50);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain with the receiver always ready
        @(posedge clk);
        draining = 1'b1;
        while (due_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[huffman_tree_decoder] OK");
        else
            $display("[huffman_tree_decoder] ERROR");
        $finish;
    end

endmodule
